[hdl/ham3126_pkg.sv]
package ham3126_pkg;

    // Field and block widths of the Hamming(31,26) stream format.
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DATA_W     = 26;
    localparam int unsigned CODE_W     = 31;
    localparam int unsigned PEND_W     = 25;
    localparam int unsigned PCNT_W     = 5;
    localparam int unsigned PARITY_N   = 5;

    // Result queue depth; one request can push two codewords.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Blocks formed from one input request, packer to encoders.
    typedef struct packed {
        logic [1:0]        n_wr;
        logic [DATA_W-1:0] data0;
        logic              last0;
        logic [DATA_W-1:0] data1;
        logic              last1;
    } blocks_t;

    // Encoded codewords of one input request, encoders to result queue.
    typedef struct packed {
        logic [1:0]        n_wr;
        logic [CODE_W-1:0] code0;
        logic              last0;
        logic [CODE_W-1:0] code1;
        logic              last1;
    } words_t;

endpackage

[hdl/ham3126_encoder.sv]
module ham3126_encoder
(
    input  logic [ham3126_pkg::DATA_W-1:0] data,
    output logic [ham3126_pkg::CODE_W-1:0] codeword
);

    logic [ham3126_pkg::CODE_W-1:0] word;
    logic [ham3126_pkg::PARITY_N-1:0] par;

    // Scatter the data bits over the positions that are not powers of two,
    // then form each parity bit over the positions whose index has bit k set.
    always_comb
    begin
        int src;
        word = '0;
        par  = '0;
        src  = 0;
        for (int pos = 1; pos <= int'(ham3126_pkg::CODE_W); pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                word[pos-1] = data[src];
                src = src + 1;
            end
        end
        for (int k = 0; k < int'(ham3126_pkg::PARITY_N); k++)
        begin
            for (int pos = 1; pos <= int'(ham3126_pkg::CODE_W); pos++)
            begin
                if (((pos >> k) & 1) != 0)
                begin
                    par[k] = par[k] ^ word[pos-1];
                end
            end
        end
        for (int k = 0; k < int'(ham3126_pkg::PARITY_N); k++)
        begin
            word[(1 << k) - 1] = par[k];
        end
        codeword = word;
    end

endmodule

[hdl/ham3126_packer.sv]
module ham3126_packer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ham3126_pkg::BYTE_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           room,
    output ham3126_pkg::blocks_t           blk
);

    logic                             in_valid_reg;
    logic [ham3126_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                             in_last_reg;
    logic [ham3126_pkg::PEND_W-1:0]   pend_bits_reg;
    logic [ham3126_pkg::PEND_W-1:0]   pend_bits_next;
    logic [ham3126_pkg::PCNT_W-1:0]   pend_cnt_reg;
    logic [ham3126_pkg::PCNT_W-1:0]   pend_cnt_next;

    logic [ham3126_pkg::PEND_W+ham3126_pkg::BYTE_W-1:0] acc;
    logic [ham3126_pkg::PEND_W+ham3126_pkg::BYTE_W-1:0] rem_mask;
    logic [5:0]                       total;
    logic [5:0]                       rem6;
    logic                             full;
    logic [ham3126_pkg::PCNT_W-1:0]   rem_cnt;
    logic [ham3126_pkg::PEND_W-1:0]   rem_bits;
    logic [ham3126_pkg::DATA_W-1:0]   blk_full;
    logic [ham3126_pkg::DATA_W-1:0]   pad_base;
    logic [ham3126_pkg::DATA_W-1:0]   blk_pad;
    logic [ham3126_pkg::PCNT_W-1:0]   pad_sh;
    logic                             has_pad;

    // Space in the result queue is checked ahead, so a request in the input
    // register always finishes without a stall.
    assign s_tready = room;

    // Join the pending bits with the new byte and cut off a full block.
    always_comb
    begin
        acc      = {pend_bits_reg, in_byte_reg};
        total    = {1'b0, pend_cnt_reg} + 6'(ham3126_pkg::BYTE_W);
        full     = total >= 6'(ham3126_pkg::DATA_W);
        rem6     = full ? (total - 6'(ham3126_pkg::DATA_W)) : total;
        rem_cnt  = rem6[ham3126_pkg::PCNT_W-1:0];
        blk_full = ham3126_pkg::DATA_W'(acc >> rem_cnt[2:0]);
        rem_mask = ({{(ham3126_pkg::PEND_W+ham3126_pkg::BYTE_W-1){1'b0}}, 1'b1} << rem_cnt)
                   - {{(ham3126_pkg::PEND_W+ham3126_pkg::BYTE_W-1){1'b0}}, 1'b1};
        rem_bits = acc[ham3126_pkg::PEND_W-1:0] & rem_mask[ham3126_pkg::PEND_W-1:0];
        pad_sh   = ham3126_pkg::PCNT_W'(ham3126_pkg::DATA_W) - rem_cnt;
        pad_base = {1'b0, rem_bits};
        blk_pad  = pad_base << pad_sh;
        has_pad  = in_last_reg && (rem_cnt != '0);
    end

    // Order the results: the full block first, then the zero-padded tail.
    always_comb
    begin
        blk       = '0;
        blk.data1 = blk_pad;
        blk.last1 = 1'b1;
        if (in_valid_reg)
        begin
            if (full)
            begin
                blk.data0 = blk_full;
                blk.last0 = in_last_reg && !has_pad;
                blk.n_wr  = has_pad ? 2'd2 : 2'd1;
            end
            else if (has_pad)
            begin
                blk.data0 = blk_pad;
                blk.last0 = 1'b1;
                blk.n_wr  = 2'd1;
            end
        end
    end

    // Pending state: keep the leftover bits, or clear after the last byte.
    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (in_valid_reg)
        begin
            if (in_last_reg)
            begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            else
            begin
                pend_bits_next = rem_bits;
                pend_cnt_next  = rem_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= s_tvalid && s_tready;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // A last byte always yields at least one codeword.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg) |-> (blk.n_wr != 2'd0))
    else $error("last byte produced no codeword");

    // The message state returns to empty after the last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg) |=> (pend_cnt_reg == '0))
    else $error("pending bits left after the last byte");

    // Leftover never reaches a full block.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg < ham3126_pkg::PCNT_W'(ham3126_pkg::DATA_W))
    else $error("pending count out of range");

endmodule

[hdl/ham3126_out_queue.sv]
module ham3126_out_queue
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ham3126_pkg::words_t            wr,
    output logic                           room,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,
    output logic                           m_tlast
);

    logic [ham3126_pkg::CODE_W:0]   entry_reg [ham3126_pkg::QUEUE_DEPTH];
    logic [ham3126_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [ham3126_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [ham3126_pkg::QPTR_W-1:0] wr_ptr_inc;
    logic [ham3126_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [ham3126_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [ham3126_pkg::QCNT_W-1:0] count_reg;
    logic [ham3126_pkg::QCNT_W-1:0] count_next;
    logic [ham3126_pkg::QCNT_W:0]   need;
    logic                           pop;

    // A new request may push two codewords on top of those now being written.
    assign need = {1'b0, count_reg} + (ham3126_pkg::QCNT_W+1)'(wr.n_wr)
                  + (ham3126_pkg::QCNT_W+1)'(2);
    assign room = need <= (ham3126_pkg::QCNT_W+1)'(ham3126_pkg::QUEUE_DEPTH);

    // Head of the queue drives the output stream.
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {1'b0, entry_reg[rd_ptr_reg][ham3126_pkg::CODE_W-1:0]};
    assign m_tlast  = entry_reg[rd_ptr_reg][ham3126_pkg::CODE_W];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_inc  = wr_ptr_reg + ham3126_pkg::QPTR_W'(1);
        wr_ptr_next = wr_ptr_reg + ham3126_pkg::QPTR_W'(wr.n_wr);
        rd_ptr_next = pop ? (rd_ptr_reg + ham3126_pkg::QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + ham3126_pkg::QCNT_W'(wr.n_wr)
                      - ham3126_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage: up to two entries written per cycle.
    always_ff @(posedge clk)
    begin
        if (wr.n_wr != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= {wr.last0, wr.code0};
        end
        if (wr.n_wr == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= {wr.last1, wr.code1};
        end
    end

    // The admission check keeps the queue from overflowing.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ham3126_pkg::QCNT_W'(ham3126_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

endmodule

[hdl/hamming_31_26_stream_encoder.sv]
// Hamming(31,26) stream encoder. Bytes enter on the s_ stream, most
// significant bit first, and are packed into a continuous bit stream that is
// cut into 26-bit blocks; each block leaves on the m_ stream as a 31-bit
// codeword (bit i is position i+1, parity at positions 1, 2, 4, 8 and 16).
// s_tlast marks the final byte of a message: any leftover bits are padded
// with zeros into a final codeword, and the final codeword carries m_tlast.
// One byte is accepted every cycle; a byte is held in the input register,
// where packing and the parity trees run, and its codewords are then
// presented from a four-entry result queue. The final byte of a message
// can push two codewords, and input is held off only while that queue
// lacks room for two more besides those now being written.
module hamming_31_26_stream_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] codeword, [31] zero fill
    output logic        m_tlast    // last_word
);

    ham3126_pkg::blocks_t blk;
    ham3126_pkg::words_t  words;
    logic                 room;
    logic [ham3126_pkg::CODE_W-1:0] code0;
    logic [ham3126_pkg::CODE_W-1:0] code1;

    // Byte packing and block formation.
    ham3126_packer u_packer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .room     (room),
        .blk      (blk)
    );

    // Encoders for the full block and the padded tail.
    ham3126_encoder u_enc0
    (
        .data     (blk.data0),
        .codeword (code0)
    );

    ham3126_encoder u_enc1
    (
        .data     (blk.data1),
        .codeword (code1)
    );

    always_comb
    begin
        words.n_wr  = blk.n_wr;
        words.code0 = code0;
        words.last0 = blk.last0;
        words.code1 = code1;
        words.last1 = blk.last1;
    end

    // Result queue toward the output stream.
    ham3126_out_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (words),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
